@@ rtl/h2r_pkg.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB package
// Widths, fixed-point constants, sector codes and stage payload types.
// ---------------------------------------------------------------------------
package h2r_pkg;

   localparam int COLOR_BITS  = 8;
   localparam int HUE_W       = 13;
   localparam int HUE_FULL    = 5760;
   localparam int SECTOR_SPAN = 960;
   localparam int SECTORS     = 6;
   localparam int F_W         = $clog2(SECTOR_SPAN);
   localparam int SECTOR_W    = $clog2(SECTORS);

   localparam longint FULL_SCALE = (longint'(1) << COLOR_BITS) - 1;
   localparam longint DEN        = FULL_SCALE * SECTOR_SPAN;
   localparam int     DEN_W      = $clog2(DEN + 1);

   // Numerator widths of the three quotients.
   localparam int PN_W = 2 * COLOR_BITS;
   localparam int QN_W = COLOR_BITS + DEN_W;

   // Truncated reciprocals; the estimate is the true quotient or one below it.
   localparam int     RCP_W = COLOR_BITS + 1;
   localparam longint RCP_P = (longint'(1) << PN_W) / FULL_SCALE;
   localparam longint RCP_Q = (longint'(1) << QN_W) / DEN;

   // Sixty-degree sectors of the hue circle.
   localparam logic [SECTOR_W-1:0] SECTOR_RY = SECTOR_W'(0);
   localparam logic [SECTOR_W-1:0] SECTOR_YG = SECTOR_W'(1);
   localparam logic [SECTOR_W-1:0] SECTOR_GC = SECTOR_W'(2);
   localparam logic [SECTOR_W-1:0] SECTOR_CB = SECTOR_W'(3);
   localparam logic [SECTOR_W-1:0] SECTOR_BM = SECTOR_W'(4);
   localparam logic [SECTOR_W-1:0] SECTOR_MR = SECTOR_W'(5);

   typedef struct packed {
      logic [SECTOR_W-1:0]   sector;
      logic [F_W-1:0]        frac;
      logic [COLOR_BITS-1:0] sat;
      logic [COLOR_BITS-1:0] bri;
   } sect_type;

   typedef struct packed {
      logic [SECTOR_W-1:0]   sector;
      logic [COLOR_BITS-1:0] bri;
      logic [DEN_W-1:0]      sf;
      logic [DEN_W-1:0]      sfc;
      logic [PN_W-1:0]       pn;
   } prod_type;

   typedef struct packed {
      logic [SECTOR_W-1:0]   sector;
      logic [COLOR_BITS-1:0] bri;
      logic [PN_W-1:0]       pn;
      logic [QN_W-1:0]       qn;
      logic [QN_W-1:0]       tn;
   } num_type;

endpackage

@@ rtl/h2r_req_if.sv @@
// ---------------------------------------------------------------------------
// HSV request channel
// Valid/ready channel that carries one HSV pixel per request.
// ---------------------------------------------------------------------------
interface h2r_req_if;
   import h2r_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [HUE_W-1:0]      hue;
   logic [COLOR_BITS-1:0] saturation;
   logic [COLOR_BITS-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

@@ rtl/h2r_rsp_if.sv @@
// ---------------------------------------------------------------------------
// RGB response channel
// Valid/ready channel that carries one RGB pixel per request.
// ---------------------------------------------------------------------------
interface h2r_rsp_if;
   import h2r_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/h2r_sector.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB sector stage
// Wraps the hue into the circle and splits it into sector and offset.
// ---------------------------------------------------------------------------
module h2r_sector (
   input  logic              clock,
   input  logic              reset,
   h2r_req_if.sink           req,
   output logic              out_valid,
   input  logic              out_ready,
   output h2r_pkg::sect_type out_data
);
   import h2r_pkg::*;

   logic             vld_ff;
   logic             stage_ready;
   sect_type         data_in;
   sect_type         data_ff;
   logic [HUE_W-1:0] hue_wrap;
   logic [HUE_W-1:0] base;

   assign stage_ready = !vld_ff || out_ready;
   assign req.ready   = stage_ready;

   always_comb begin
      hue_wrap = (req.hue >= HUE_W'(HUE_FULL)) ? '0 : req.hue;
      base     = '0;
      data_in.sector = SECTOR_RY;
      for (int k = 1; k < SECTORS; k++) begin
         if (hue_wrap >= HUE_W'(k * SECTOR_SPAN)) begin
            data_in.sector = SECTOR_W'(k);
            base           = HUE_W'(k * SECTOR_SPAN);
         end
      end
      data_in.frac = F_W'(hue_wrap - base);
      data_in.sat  = req.saturation;
      data_in.bri  = req.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (stage_ready) begin
         vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && req.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/h2r_mult.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB product stages
// Two register stages that form the numerators of p, q and t.
// ---------------------------------------------------------------------------
module h2r_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  h2r_pkg::sect_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output h2r_pkg::num_type  out_data
);
   import h2r_pkg::*;

   logic                      vld2_ff;
   logic                      vld3_ff;
   logic                      ready2;
   logic                      ready3;
   prod_type                  prod_in;
   prod_type                  prod_ff;
   num_type                   num_in;
   num_type                   num_ff;
   logic [COLOR_BITS+F_W-1:0] sf_full;
   logic [COLOR_BITS+F_W-1:0] sfc_full;
   logic [F_W-1:0]            frac_c;
   logic [DEN_W-1:0]          q_fac;
   logic [DEN_W-1:0]          t_fac;

   assign ready3   = !vld3_ff || out_ready;
   assign ready2   = !vld2_ff || ready3;
   assign in_ready = ready2;

   // Stage 2: s*f, s*(span - f) and v*(full scale - s).
   always_comb begin
      frac_c          = F_W'(SECTOR_SPAN) - in_data.frac;
      sf_full         = (COLOR_BITS+F_W)'(in_data.sat) * (COLOR_BITS+F_W)'(in_data.frac);
      sfc_full        = (COLOR_BITS+F_W)'(in_data.sat) * (COLOR_BITS+F_W)'(frac_c);
      prod_in.sector  = in_data.sector;
      prod_in.bri     = in_data.bri;
      prod_in.sf      = DEN_W'(sf_full);
      prod_in.sfc     = DEN_W'(sfc_full);
      prod_in.pn      = PN_W'(in_data.bri) *
                        PN_W'(COLOR_BITS'(FULL_SCALE) - in_data.sat);
   end

   // Stage 3: v*(den - s*f) and v*(den - s*(span - f)).
   always_comb begin
      q_fac         = DEN_W'(DEN) - prod_ff.sf;
      t_fac         = DEN_W'(DEN) - prod_ff.sfc;
      num_in.sector = prod_ff.sector;
      num_in.bri    = prod_ff.bri;
      num_in.pn     = prod_ff.pn;
      num_in.qn     = QN_W'(prod_ff.bri) * QN_W'(q_fac);
      num_in.tn     = QN_W'(prod_ff.bri) * QN_W'(t_fac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (ready2) begin
            vld2_ff <= in_valid;
         end
         if (ready3) begin
            vld3_ff <= vld2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && in_valid) begin
         prod_ff <= prod_in;
      end
      if (ready3 && vld2_ff) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = vld3_ff;
   assign out_data  = num_ff;

endmodule

@@ rtl/h2r_div.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB quotient stages
// Divides by the constant denominators through truncated reciprocals, fixes
// the estimates by one compare, and routes p, q, t and v to the outputs.
// ---------------------------------------------------------------------------
module h2r_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  h2r_pkg::num_type in_data,
   h2r_rsp_if.source        rsp
);
   import h2r_pkg::*;

   logic                        vld4_ff;
   logic                        vld5_ff;
   logic                        ready4;
   logic                        ready5;
   num_type                     num_ff;
   logic [COLOR_BITS-1:0]       pe_in;
   logic [COLOR_BITS-1:0]       qe_in;
   logic [COLOR_BITS-1:0]       te_in;
   logic [COLOR_BITS-1:0]       pe_ff;
   logic [COLOR_BITS-1:0]       qe_ff;
   logic [COLOR_BITS-1:0]       te_ff;
   logic [PN_W+RCP_W-1:0]       p_scaled;
   logic [QN_W+RCP_W-1:0]       q_scaled;
   logic [QN_W+RCP_W-1:0]       t_scaled;
   logic [PN_W-1:0]             p_rem;
   logic [QN_W-1:0]             q_rem;
   logic [QN_W-1:0]             t_rem;
   logic [COLOR_BITS-1:0]       p_fix;
   logic [COLOR_BITS-1:0]       q_fix;
   logic [COLOR_BITS-1:0]       t_fix;
   logic [COLOR_BITS-1:0]       red_in;
   logic [COLOR_BITS-1:0]       green_in;
   logic [COLOR_BITS-1:0]       blue_in;
   logic [COLOR_BITS-1:0]       red_ff;
   logic [COLOR_BITS-1:0]       green_ff;
   logic [COLOR_BITS-1:0]       blue_ff;

   assign ready5   = !vld5_ff || rsp.ready;
   assign ready4   = !vld4_ff || ready5;
   assign in_ready = ready4;

   // Stage 4: quotient estimates.
   always_comb begin
      p_scaled = (PN_W+RCP_W)'(in_data.pn) * (PN_W+RCP_W)'(RCP_P);
      q_scaled = (QN_W+RCP_W)'(in_data.qn) * (QN_W+RCP_W)'(RCP_Q);
      t_scaled = (QN_W+RCP_W)'(in_data.tn) * (QN_W+RCP_W)'(RCP_Q);
      pe_in    = p_scaled[PN_W +: COLOR_BITS];
      qe_in    = q_scaled[QN_W +: COLOR_BITS];
      te_in    = t_scaled[QN_W +: COLOR_BITS];
   end

   // Stage 5: the remainder tells whether the estimate is one short.
   always_comb begin
      p_rem = num_ff.pn - PN_W'(pe_ff) * PN_W'(FULL_SCALE);
      q_rem = num_ff.qn - QN_W'(qe_ff) * QN_W'(DEN);
      t_rem = num_ff.tn - QN_W'(te_ff) * QN_W'(DEN);
      p_fix = pe_ff + COLOR_BITS'(p_rem >= PN_W'(FULL_SCALE));
      q_fix = qe_ff + COLOR_BITS'(q_rem >= QN_W'(DEN));
      t_fix = te_ff + COLOR_BITS'(t_rem >= QN_W'(DEN));

      // Zero saturation needs no case of its own: p, q and t all come out as v.
      unique case (num_ff.sector)
         SECTOR_RY: begin
            red_in = num_ff.bri; green_in = t_fix;      blue_in = p_fix;
         end
         SECTOR_YG: begin
            red_in = q_fix;      green_in = num_ff.bri; blue_in = p_fix;
         end
         SECTOR_GC: begin
            red_in = p_fix;      green_in = num_ff.bri; blue_in = t_fix;
         end
         SECTOR_CB: begin
            red_in = p_fix;      green_in = q_fix;      blue_in = num_ff.bri;
         end
         SECTOR_BM: begin
            red_in = t_fix;      green_in = p_fix;      blue_in = num_ff.bri;
         end
         default: begin
            red_in = num_ff.bri; green_in = p_fix;      blue_in = q_fix;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (ready4) begin
            vld4_ff <= in_valid;
         end
         if (ready5) begin
            vld5_ff <= vld4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && in_valid) begin
         num_ff <= in_data;
         pe_ff  <= pe_in;
         qe_ff  <= qe_in;
         te_ff  <= te_in;
      end
      if (ready5 && vld4_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp.valid = vld5_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;

   // The reciprocal estimates are never above the quotient and at most one below.
   a_p_est: assert property (@(posedge clock) disable iff (reset)
      vld4_ff |-> ({1'b0, p_rem} < (PN_W+1)'(2 * FULL_SCALE)))
      else $error("p estimate out of range");

   a_qt_est: assert property (@(posedge clock) disable iff (reset)
      vld4_ff |-> (({1'b0, q_rem} < (QN_W+1)'(2 * DEN)) &&
                   ({1'b0, t_rem} < (QN_W+1)'(2 * DEN))))
      else $error("q or t estimate out of range");

   a_p_min: assert property (@(posedge clock) disable iff (reset)
      vld4_ff |-> ((p_fix <= q_fix) && (p_fix <= t_fix) &&
                   (q_fix <= num_ff.bri) && (t_fix <= num_ff.bri)))
      else $error("p, q, t ordering broken");

endmodule

@@ rtl/hsv_to_rgb_unit.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that converts one HSV pixel to RGB every clock while rsp.ready stays high.
// ---------------------------------------------------------------------------
// Usage:
//   req carries hue in sixteenths of a degree (5760 and above wraps to 0),
//   saturation and brightness as fractions of full scale. rsp carries red,
//   green and blue on the same scale as brightness.
//   A request is taken when req.valid and req.ready are both high; a result
//   leaves when rsp.valid and rsp.ready are both high.
//   Throughput is one pixel per clock while rsp.ready stays high: each
//   stage holds one pixel, and its ready is high whenever it is empty or
//   the stage after it moves.
//   Stages: hue wrap and sector split, saturation products, brightness
//   products, reciprocal quotient estimates, remainder fix and channel mux.
//   When the receiver stalls, the pipeline keeps filling its empty stages and
//   then holds every pixel in place until rsp.ready returns.
//   Synchronous reset empties all stages; pixel data is not cleared.
// ---------------------------------------------------------------------------
module hsv_to_rgb_unit (
   input logic       clock,
   input logic       reset,
   h2r_req_if.sink   req,
   h2r_rsp_if.source rsp
);
   import h2r_pkg::*;

   logic     sect_valid;
   logic     sect_ready;
   sect_type sect_data;
   logic     num_valid;
   logic     num_ready;
   num_type  num_data;

   h2r_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (sect_valid),
      .out_ready (sect_ready),
      .out_data  (sect_data)
   );

   h2r_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sect_valid),
      .in_ready  (sect_ready),
      .in_data   (sect_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   h2r_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (num_valid),
      .in_ready (num_ready),
      .in_data  (num_data),
      .rsp      (rsp)
   );

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV pixels into hsv_to_rgb_unit through a valid/ready request
// channel and checks every RGB result against an internal integer model.
// A directed set of corner pixels comes first, then random pixels in three
// legs: slow receiver, slow sender, and full rate on both sides.
// ---------------------------------------------------------------------------
module tb_top;
   import h2r_pkg::*;

   typedef struct packed {
      logic [HUE_W-1:0]      hue;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] brightness;
   } hsv_pix_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_pix_type;

   typedef struct {
      hsv_pix_type pix;
      int          leg;
   } hsv_item_type;

   typedef struct {
      hsv_pix_type src;
      rgb_pix_type rgb;
   } rgb_due_type;

   localparam int RANDOM_PIXELS = 1900;
   localparam int LEGS          = 3;

   logic clock;
   logic reset;

   h2r_req_if req_ch ();
   h2r_rsp_if rsp_ch ();

   hsv_to_rgb_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   hsv_item_type hsv_pending_q [$];
   rgb_due_type  rgb_due_q [$];
   int           error_count = 0;
   int           leg = 0;
   // Idle percentages per leg for the sender and for the receiver.
   int           send_gap_pct [LEGS] = '{9, 65, 0};
   int           take_gap_pct [LEGS] = '{65, 9, 0};

   function automatic rgb_pix_type convert_hsv(hsv_pix_type px);
      longint unsigned fs, hue, s, v, den, f, p, q, t, r, g, b;
      logic [SECTOR_W-1:0] sector;
      rgb_pix_type c;
      fs  = FULL_SCALE;
      hue = px.hue;
      s   = px.saturation;
      v   = px.brightness;
      if (s == 0) begin
         r = v;
         g = v;
         b = v;
      end else begin
         if (hue >= HUE_FULL) hue = 0;
         sector = SECTOR_W'(hue / SECTOR_SPAN);
         f      = hue % SECTOR_SPAN;
         den    = fs * SECTOR_SPAN;
         p      = (v * (fs - s)) / fs;
         q      = (v * (den - s * f)) / den;
         t      = (v * (den - s * (SECTOR_SPAN - f))) / den;
         case (sector)
            SECTOR_RY: begin r = v; g = t; b = p; end
            SECTOR_YG: begin r = q; g = v; b = p; end
            SECTOR_GC: begin r = p; g = v; b = t; end
            SECTOR_CB: begin r = p; g = q; b = v; end
            SECTOR_BM: begin r = t; g = p; b = v; end
            default:   begin r = v; g = p; b = q; end
         endcase
      end
      c.red   = COLOR_BITS'(r);
      c.green = COLOR_BITS'(g);
      c.blue  = COLOR_BITS'(b);
      return c;
   endfunction

   task automatic note_error(string msg);
      error_count++;
      $display("%0t ERROR %s", $time, msg);
   endtask

   task automatic check_channel(string name, logic [COLOR_BITS-1:0] got,
                                logic [COLOR_BITS-1:0] want, hsv_pix_type src);
      if (got !== want)
         note_error($sformatf("%s got %0d want %0d for hue %0d sat %0d bri %0d",
                              name, got, want, src.hue, src.saturation,
                              src.brightness));
   endtask

   task automatic add_pixel(int hue, int sat, int bri, int leg_idx);
      hsv_item_type it;
      it.pix.hue        = HUE_W'(hue);
      it.pix.saturation = COLOR_BITS'(sat);
      it.pix.brightness = COLOR_BITS'(bri);
      it.leg            = leg_idx;
      hsv_pending_q = {hsv_pending_q, it};
   endtask

   always #1 clock = ~clock;

   // Request driver: records the expected result of each accepted request
   // and presents the next pending pixel unless it decides to idle.
   always @(posedge clock) begin : drive_hsv
      hsv_item_type nxt;
      rgb_due_type  due_new;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_new.src.hue        = req_ch.hue;
            due_new.src.saturation = req_ch.saturation;
            due_new.src.brightness = req_ch.brightness;
            due_new.rgb            = convert_hsv(due_new.src);
            rgb_due_q = {rgb_due_q, due_new};
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (hsv_pending_q.size() != 0 &&
                $urandom_range(99) >= send_gap_pct[leg]) begin
               nxt = hsv_pending_q.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.hue        <= nxt.pix.hue;
               req_ch.saturation <= nxt.pix.saturation;
               req_ch.brightness <= nxt.pix.brightness;
               leg               <= nxt.leg;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with a randomly stalling receiver.
   always @(posedge clock) begin : check_rgb
      rgb_due_type due;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rgb_due_q.size() == 0) begin
               note_error($sformatf("unexpected result r %0d g %0d b %0d",
                                    rsp_ch.red, rsp_ch.green, rsp_ch.blue));
            end else begin
               due = rgb_due_q.pop_front();
               check_channel("red", rsp_ch.red, due.rgb.red, due.src);
               check_channel("green", rsp_ch.green, due.rgb.green, due.src);
               check_channel("blue", rsp_ch.blue, due.rgb.blue, due.src);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= take_gap_pct[leg]);
      end
   end

   initial begin : stimulus
      int hue, sat, bri, k, leg_idx;
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.hue        = '0;
      req_ch.saturation = '0;
      req_ch.brightness = '0;
      rsp_ch.ready      = 1'b0;

      // Corner pixels: the first hue of every sector, the last hue of sectors RY, YG,
      // CB and MR, the wrapped hue range, zero saturation and the extremes of saturation and brightness.
      add_pixel(0, 255, 255, 0);
      add_pixel(959, 255, 255, 0);
      add_pixel(960, 255, 255, 0);
      add_pixel(1919, 200, 255, 0);
      add_pixel(1920, 255, 128, 0);
      add_pixel(2880, 255, 255, 0);
      add_pixel(3839, 255, 255, 0);
      add_pixel(3840, 128, 200, 0);
      add_pixel(4800, 255, 255, 0);
      add_pixel(5759, 255, 255, 0);
      add_pixel(5760, 255, 255, 0);
      add_pixel(8191, 255, 255, 0);
      add_pixel(7000, 100, 50, 0);
      add_pixel(480, 0, 77, 0);
      add_pixel(8191, 0, 255, 0);
      add_pixel(3000, 0, 0, 0);
      add_pixel(2400, 1, 255, 0);
      add_pixel(4000, 255, 0, 0);
      add_pixel(1440, 255, 1, 0);
      add_pixel(5280, 128, 128, 0);
      add_pixel(100, 254, 254, 0);
      add_pixel(4321, 170, 85, 0);

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         leg_idx = (i * LEGS) / RANDOM_PIXELS;
         k = $urandom_range(99);
         if (k < 12)
            hue = $urandom_range(8191, HUE_FULL);
         else if (k < 20)
            hue = $urandom_range(5) * SECTOR_SPAN +
                  ($urandom_range(1) ? SECTOR_SPAN - 1 : 0);
         else
            hue = $urandom_range(HUE_FULL - 1, 0);
         k = $urandom_range(99);
         sat = (k < 6) ? 0 : (k < 12) ? 255 : $urandom_range(255);
         k = $urandom_range(99);
         bri = (k < 3) ? 0 : (k < 8) ? 255 : $urandom_range(255);
         add_pixel(hue, sat, bri, leg_idx);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (hsv_pending_q.size() != 0 || req_ch.valid || rgb_due_q.size() != 0)
         @(posedge clock);
      // Let any stray result drain out of the five-stage pipeline.
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
